@@ src/pinhole_projection_with_distortion_unit_defines.svh @@
// Assertion macros used by the checker file of the projection unit.
`ifndef PINHOLE_PROJECTION_WITH_DISTORTION_UNIT_DEFINES_SVH
`define PINHOLE_PROJECTION_WITH_DISTORTION_UNIT_DEFINES_SVH

// Same-cycle implication, sampled on clk, quiet during reset.
`define PPD_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("projection unit check failed");

// Next-cycle implication, sampled on clk, quiet during reset.
`define PPD_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("projection unit check failed");

`endif

@@ src/ppd_pkg.sv @@
`timescale 1ns / 1ps
// Shared constants, codes and fixed-point helpers of the projection unit.
package ppd_pkg;

  localparam int DIV_STEPS = 56;

  localparam logic signed [31:0] DIST_THR = 32'sd168;
  localparam logic signed [31:0] Q_ONE    = 32'sd16777216;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_DEPTH = 2'd1;
  localparam logic [1:0] ST_SAT   = 2'd2;

  localparam logic [3:0] CFG_FOCAL_X   = 4'd0;
  localparam logic [3:0] CFG_FOCAL_Y   = 4'd1;
  localparam logic [3:0] CFG_PRINCIPAL = 4'd2;
  localparam logic [3:0] CFG_K1        = 4'd3;
  localparam logic [3:0] CFG_K2        = 4'd4;
  localparam logic [3:0] CFG_P1        = 4'd5;
  localparam logic [3:0] CFG_P2        = 4'd6;
  localparam logic [3:0] CFG_K3        = 4'd7;

  // Q8.24 times Q8.24, rounded half up back to Q8.24.
  function automatic logic signed [39:0] qmul(input logic signed [31:0] a,
                                              input logic signed [31:0] b);
    logic signed [63:0] p;
    p = 64'(a) * 64'(b);
    p = p + 64'sd8388608;
    return p[63:24];
  endfunction

  function automatic logic ovf32(input logic signed [47:0] v);
    return (v > 48'sd2147483647) || (v < -48'sd2147483648);
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [47:0] v);
    logic signed [31:0] r;
    if (v > 48'sd2147483647) r = 32'sh7FFFFFFF;
    else if (v < -48'sd2147483648) r = 32'sh80000000;
    else r = v[31:0];
    return r;
  endfunction

endpackage

@@ src/pinhole_projection_with_distortion_unit.sv @@
`timescale 1ns / 1ps
// Top level of the pinhole projection unit with lens distortion.
//
// Usage: push camera-frame points (x, y, z in signed Q16.16) on the in_ channel
// and take pixel coordinates (signed Q18.8) plus a status code on the out_ channel.
// Both channels are valid/ready; a word moves when valid and ready are high.
// One word is accepted every cycle unless stalled; each point gives exactly
// one result word. A point passes the divider (an entry stage, one radix-2
// quotient bit per stage for 56 bits, and a sign/saturate stage), the distortion
// pipe and the focal/offset stage. Unstalled, the rate is one word per cycle.
// All stages advance together: when the output register holds a word that is
// not taken, the whole pipe holds and in_ready drops; nothing is lost or
// repeated. Reset clears every valid bit and loads the default camera
// (focal 500, principal point 320/240, no distortion). Write configuration
// through cfg_we/cfg_index/cfg_data only while the pipe is empty; unknown
// indexes are ignored. Distortion is applied only when |k1| exceeds 168.
module pinhole_projection_with_distortion_unit import ppd_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [31:0] in_x_cam,
  input  logic signed [31:0] in_y_cam,
  input  logic signed [31:0] in_z_cam,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [25:0] out_pixel_u,
  output logic signed [25:0] out_pixel_v,
  output logic [1:0]         out_status,
  input  logic               cfg_we,
  input  logic [3:0]         cfg_index,
  input  logic [47:0]        cfg_data
);

  logic [23:0]        focal_x_r, focal_y_r;
  logic [47:0]        pp_r;
  logic signed [31:0] k1_r, k2_r, k3_r, p1_r, p2_r;

  logic en, dist_en;

  logic               dv_vld, dv_ovf, dv_zbad;
  logic signed [31:0] dv_xn, dv_yn;
  logic               ds_vld, ds_sat, ds_zbad;
  logic signed [31:0] ds_xd, ds_yd;

  // Advance the pipe whenever the output register is free or being drained.
  assign en       = !out_valid || out_ready;
  assign in_ready = en;
  assign dist_en  = (k1_r > DIST_THR) || (k1_r < -DIST_THR);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      focal_x_r <= 24'd128000;
      focal_y_r <= 24'd128000;
      pp_r      <= 48'd1374389596160;
      k1_r      <= '0;
      k2_r      <= '0;
      k3_r      <= '0;
      p1_r      <= '0;
      p2_r      <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_FOCAL_X:   focal_x_r <= cfg_data[23:0];
        CFG_FOCAL_Y:   focal_y_r <= cfg_data[23:0];
        CFG_PRINCIPAL: pp_r      <= cfg_data;
        CFG_K1:        k1_r      <= $signed(cfg_data[31:0]);
        CFG_K2:        k2_r      <= $signed(cfg_data[31:0]);
        CFG_P1:        p1_r      <= $signed(cfg_data[31:0]);
        CFG_P2:        p2_r      <= $signed(cfg_data[31:0]);
        CFG_K3:        k3_r      <= $signed(cfg_data[31:0]);
        default: ;
      endcase
    end
  end

  // Normalize by depth.
  ppd_div u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .in_vld  (in_valid),
    .x       (in_x_cam),
    .y       (in_y_cam),
    .z       (in_z_cam),
    .out_vld (dv_vld),
    .xn      (dv_xn),
    .yn      (dv_yn),
    .ovf     (dv_ovf),
    .zbad    (dv_zbad)
  );

  // Apply lens distortion, or pass the normalized point through.
  ppd_dist u_dist (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .dist_en  (dist_en),
    .k1       (k1_r),
    .k2       (k2_r),
    .k3       (k3_r),
    .p1       (p1_r),
    .p2       (p2_r),
    .in_vld   (dv_vld),
    .xn       (dv_xn),
    .yn       (dv_yn),
    .in_sat   (dv_ovf),
    .in_zbad  (dv_zbad),
    .out_vld  (ds_vld),
    .xd       (ds_xd),
    .yd       (ds_yd),
    .out_sat  (ds_sat),
    .out_zbad (ds_zbad)
  );

  // Scale to pixels; the last register here is the output register.
  ppd_pix u_pix (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .focal_x (focal_x_r),
    .focal_y (focal_y_r),
    .cx      (pp_r[47:24]),
    .cy      (pp_r[23:0]),
    .in_vld  (ds_vld),
    .xd      (ds_xd),
    .yd      (ds_yd),
    .in_sat  (ds_sat),
    .in_zbad (ds_zbad),
    .out_vld (out_valid),
    .pixel_u (out_pixel_u),
    .pixel_v (out_pixel_v),
    .status  (out_status)
  );

endmodule

@@ src/ppd_div.sv @@
`timescale 1ns / 1ps
// Pipelined restoring divider giving x/z and y/z in signed Q8.24.
module ppd_div import ppd_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               en,
  input  logic               in_vld,
  input  logic signed [31:0] x,
  input  logic signed [31:0] y,
  input  logic signed [31:0] z,
  output logic               out_vld,
  output logic signed [31:0] xn,
  output logic signed [31:0] yn,
  output logic               ovf,
  output logic               zbad
);

  typedef struct packed {
    logic [30:0] rem;
    logic [55:0] dq;
  } div_st_t;

  typedef struct packed {
    logic               ovf;
    logic signed [31:0] val;
  } div_res_t;

  function automatic div_st_t step(input div_st_t s, input logic [30:0] d);
    div_st_t    r;
    logic [31:0] t;
    logic        ge;
    t  = {s.rem, s.dq[55]};
    ge = (t >= {1'b0, d});
    r.rem = ge ? 31'(t - {1'b0, d}) : t[30:0];
    r.dq  = {s.dq[54:0], ge};
    return r;
  endfunction

  function automatic div_res_t finish(input logic [55:0] q, input logic neg);
    div_res_t r;
    if (!neg) begin
      r.ovf = |q[55:31];
      r.val = r.ovf ? 32'sh7FFFFFFF : $signed(q[31:0]);
    end else begin
      r.ovf = (|q[55:32]) || (q[31] && (|q[30:0]));
      r.val = r.ovf ? 32'sh80000000 : $signed(~q[31:0] + 32'd1);
    end
    return r;
  endfunction

  div_st_t      sx_r [0:DIV_STEPS];
  div_st_t      sy_r [0:DIV_STEPS];
  logic [30:0]  d_r  [0:DIV_STEPS];
  logic         nx_r [0:DIV_STEPS];
  logic         ny_r [0:DIV_STEPS];
  logic         zb_r [0:DIV_STEPS];
  logic [DIV_STEPS:0] vld_r;

  logic [31:0] ax, ay;
  div_res_t    rx, ry;
  logic               out_vld_r, ovf_r, zbad_r;
  logic signed [31:0] xn_r, yn_r;

  assign ax = x[31] ? (~x + 32'd1) : x;
  assign ay = y[31] ? (~y + 32'd1) : y;

  always_ff @(posedge clk) begin
    if (!rst_n) vld_r[0] <= 1'b0;
    else if (en) vld_r[0] <= in_vld;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sx_r[0] <= '{rem: '0, dq: {ax, 24'd0}};
      sy_r[0] <= '{rem: '0, dq: {ay, 24'd0}};
      d_r[0]  <= z[30:0];
      nx_r[0] <= x[31];
      ny_r[0] <= y[31];
      zb_r[0] <= z[31] || (z == 32'sd0);
    end
  end

  for (genvar i = 0; i < DIV_STEPS; i++) begin : g_step
    always_ff @(posedge clk) begin
      if (!rst_n) vld_r[i+1] <= 1'b0;
      else if (en) vld_r[i+1] <= vld_r[i];
    end
    always_ff @(posedge clk) begin
      if (en) begin
        sx_r[i+1] <= step(sx_r[i], d_r[i]);
        sy_r[i+1] <= step(sy_r[i], d_r[i]);
        d_r[i+1]  <= d_r[i];
        nx_r[i+1] <= nx_r[i];
        ny_r[i+1] <= ny_r[i];
        zb_r[i+1] <= zb_r[i];
      end
    end
  end

  assign rx = finish(sx_r[DIV_STEPS].dq, nx_r[DIV_STEPS]);
  assign ry = finish(sy_r[DIV_STEPS].dq, ny_r[DIV_STEPS]);

  always_ff @(posedge clk) begin
    if (!rst_n) out_vld_r <= 1'b0;
    else if (en) out_vld_r <= vld_r[DIV_STEPS];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      xn_r   <= rx.val;
      yn_r   <= ry.val;
      ovf_r  <= rx.ovf | ry.ovf;
      zbad_r <= zb_r[DIV_STEPS];
    end
  end

  assign out_vld = out_vld_r;
  assign xn      = xn_r;
  assign yn      = yn_r;
  assign ovf     = ovf_r;
  assign zbad    = zbad_r;

endmodule

@@ src/ppd_dist.sv @@
`timescale 1ns / 1ps
// Eight-stage radial and tangential distortion of normalized coordinates.
module ppd_dist import ppd_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               en,
  input  logic               dist_en,
  input  logic signed [31:0] k1,
  input  logic signed [31:0] k2,
  input  logic signed [31:0] k3,
  input  logic signed [31:0] p1,
  input  logic signed [31:0] p2,
  input  logic               in_vld,
  input  logic signed [31:0] xn,
  input  logic signed [31:0] yn,
  input  logic               in_sat,
  input  logic               in_zbad,
  output logic               out_vld,
  output logic signed [31:0] xd,
  output logic signed [31:0] yd,
  output logic               out_sat,
  output logic               out_zbad
);

  logic [8:1] vld_r;
  logic signed [31:0] xn_r [1:8];
  logic signed [31:0] yn_r [1:8];
  logic               sat_r [1:8];
  logic               zb_r  [1:8];

  logic signed [39:0] x2_1_r, y2_1_r, xy_1_r;
  logic signed [39:0] x2_2_r, y2_2_r;
  logic signed [31:0] r2_2_r, xy_2_r;
  logic signed [31:0] r2_3_r, r4_3_r, tx_3_r, ty_3_r;
  logic signed [39:0] k1r2_3_r, p1xy_3_r, p2xy_3_r;
  logic signed [31:0] r6_4_r;
  logic signed [39:0] k1r2_4_r, k2r4_4_r, p1xy_4_r, p2xy_4_r, p2tx_4_r, p1ty_4_r;
  logic signed [39:0] k1r2_5_r, k2r4_5_r, k3r6_5_r, p1xy_5_r, p2xy_5_r, p2tx_5_r, p1ty_5_r;
  logic signed [31:0] rad_6_r;
  logic signed [39:0] p1xy_6_r, p2xy_6_r, p2tx_6_r, p1ty_6_r;
  logic signed [39:0] xnr_7_r, ynr_7_r, p1xy_7_r, p2xy_7_r, p2tx_7_r, p1ty_7_r;
  logic signed [31:0] xd_8_r, yd_8_r;

  logic signed [40:0] r2w;
  logic signed [42:0] txw, tyw, radw, xdw, ydw;
  logic signed [39:0] r4w, r6w;
  logic s2, s3, s4, s6, s8;

  assign r2w  = 41'(x2_1_r) + 41'(y2_1_r);
  assign txw  = 43'(r2_2_r) + (43'(x2_2_r) <<< 1);
  assign tyw  = 43'(r2_2_r) + (43'(y2_2_r) <<< 1);
  assign r4w  = qmul(r2_2_r, r2_2_r);
  assign r6w  = qmul(r4_3_r, r2_3_r);
  assign radw = 43'(Q_ONE) + 43'(k1r2_5_r) + 43'(k2r4_5_r) + 43'(k3r6_5_r);
  assign xdw  = 43'(xnr_7_r) + (43'(p1xy_7_r) <<< 1) + 43'(p2tx_7_r);
  assign ydw  = 43'(ynr_7_r) + 43'(p1ty_7_r) + (43'(p2xy_7_r) <<< 1);

  // Flag saturation of the distortion arithmetic only when the distortion path is in use.
  assign s2 = dist_en && (ovf32(48'(r2w)) || ovf32(48'(xy_1_r)));
  assign s3 = dist_en && (ovf32(48'(txw)) || ovf32(48'(tyw)) || ovf32(48'(r4w)));
  assign s4 = dist_en && ovf32(48'(r6w));
  assign s6 = dist_en && ovf32(48'(radw));
  assign s8 = dist_en && (ovf32(48'(xdw)) || ovf32(48'(ydw)));

  always_ff @(posedge clk) begin
    if (!rst_n) vld_r <= '0;
    else if (en) vld_r <= {vld_r[7:1], in_vld};
  end

  always_ff @(posedge clk) begin
    if (en) begin
      xn_r[1] <= xn;  yn_r[1] <= yn;  sat_r[1] <= in_sat;  zb_r[1] <= in_zbad;
      for (int i = 2; i <= 8; i++) begin
        xn_r[i] <= xn_r[i-1];
        yn_r[i] <= yn_r[i-1];
        zb_r[i] <= zb_r[i-1];
      end
      sat_r[2] <= sat_r[1] | s2;
      sat_r[3] <= sat_r[2] | s3;
      sat_r[4] <= sat_r[3] | s4;
      sat_r[5] <= sat_r[4];
      sat_r[6] <= sat_r[5] | s6;
      sat_r[7] <= sat_r[6];
      sat_r[8] <= sat_r[7] | s8;

      x2_1_r <= qmul(xn, xn);
      y2_1_r <= qmul(yn, yn);
      xy_1_r <= qmul(xn, yn);

      x2_2_r <= x2_1_r;
      y2_2_r <= y2_1_r;
      r2_2_r <= sat32(48'(r2w));
      xy_2_r <= sat32(48'(xy_1_r));

      r2_3_r   <= r2_2_r;
      r4_3_r   <= sat32(48'(r4w));
      tx_3_r   <= sat32(48'(txw));
      ty_3_r   <= sat32(48'(tyw));
      k1r2_3_r <= qmul(k1, r2_2_r);
      p1xy_3_r <= qmul(p1, xy_2_r);
      p2xy_3_r <= qmul(p2, xy_2_r);

      r6_4_r   <= sat32(48'(r6w));
      k1r2_4_r <= k1r2_3_r;
      k2r4_4_r <= qmul(k2, r4_3_r);
      p1xy_4_r <= p1xy_3_r;
      p2xy_4_r <= p2xy_3_r;
      p2tx_4_r <= qmul(p2, tx_3_r);
      p1ty_4_r <= qmul(p1, ty_3_r);

      k1r2_5_r <= k1r2_4_r;
      k2r4_5_r <= k2r4_4_r;
      k3r6_5_r <= qmul(k3, r6_4_r);
      p1xy_5_r <= p1xy_4_r;
      p2xy_5_r <= p2xy_4_r;
      p2tx_5_r <= p2tx_4_r;
      p1ty_5_r <= p1ty_4_r;

      rad_6_r  <= sat32(48'(radw));
      p1xy_6_r <= p1xy_5_r;
      p2xy_6_r <= p2xy_5_r;
      p2tx_6_r <= p2tx_5_r;
      p1ty_6_r <= p1ty_5_r;

      xnr_7_r  <= qmul(xn_r[6], rad_6_r);
      ynr_7_r  <= qmul(yn_r[6], rad_6_r);
      p1xy_7_r <= p1xy_6_r;
      p2xy_7_r <= p2xy_6_r;
      p2tx_7_r <= p2tx_6_r;
      p1ty_7_r <= p1ty_6_r;

      xd_8_r <= dist_en ? sat32(48'(xdw)) : xn_r[7];
      yd_8_r <= dist_en ? sat32(48'(ydw)) : yn_r[7];
    end
  end

  assign out_vld  = vld_r[8];
  assign xd       = xd_8_r;
  assign yd       = yd_8_r;
  assign out_sat  = sat_r[8];
  assign out_zbad = zb_r[8];

endmodule

@@ src/ppd_pix.sv @@
`timescale 1ns / 1ps
// Focal scaling, principal point offset, clamping and status of a result word.
module ppd_pix import ppd_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               en,
  input  logic [23:0]        focal_x,
  input  logic [23:0]        focal_y,
  input  logic [23:0]        cx,
  input  logic [23:0]        cy,
  input  logic               in_vld,
  input  logic signed [31:0] xd,
  input  logic signed [31:0] yd,
  input  logic               in_sat,
  input  logic               in_zbad,
  output logic               out_vld,
  output logic signed [25:0] pixel_u,
  output logic signed [25:0] pixel_v,
  output logic [1:0]         status
);

  logic [1:0] vld_r;
  logic signed [56:0] pu_r, pv_r;
  logic               sat_r, zb_r;
  logic signed [25:0] u_r, v_r;
  logic [1:0]         st_r;

  logic signed [56:0] pu_rnd, pv_rnd;
  logic signed [34:0] uw, vw;
  logic cu, cv;

  assign pu_rnd = pu_r + 57'sd8388608;
  assign pv_rnd = pv_r + 57'sd8388608;
  assign uw = 35'($signed(pu_rnd[56:24])) + $signed({11'd0, cx});
  assign vw = 35'($signed(pv_rnd[56:24])) + $signed({11'd0, cy});
  assign cu = (uw > 35'sd33554431) || (uw < -35'sd33554432);
  assign cv = (vw > 35'sd33554431) || (vw < -35'sd33554432);

  function automatic logic signed [25:0] clamp26(input logic signed [34:0] w);
    logic signed [25:0] r;
    if (w > 35'sd33554431) r = 26'sh1FFFFFF;
    else if (w < -35'sd33554432) r = 26'sh2000000;
    else r = w[25:0];
    return r;
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) vld_r <= '0;
    else if (en) vld_r <= {vld_r[0], in_vld};
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pu_r  <= 57'(xd) * $signed({33'd0, focal_x});
      pv_r  <= 57'(yd) * $signed({33'd0, focal_y});
      sat_r <= in_sat;
      zb_r  <= in_zbad;

      if (zb_r) begin
        u_r  <= '0;
        v_r  <= '0;
        st_r <= ST_DEPTH;
      end else begin
        u_r  <= clamp26(uw);
        v_r  <= clamp26(vw);
        st_r <= (sat_r || cu || cv) ? ST_SAT : ST_OK;
      end
    end
  end

  assign out_vld = vld_r[1];
  assign pixel_u = u_r;
  assign pixel_v = v_r;
  assign status  = st_r;

endmodule

@@ src/ppd_chk.sv @@
`timescale 1ns / 1ps
// Port-level checker of the projection unit and its bind.
`include "pinhole_projection_with_distortion_unit_defines.svh"
module ppd_chk import ppd_pkg::*; (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_ready,
  input logic signed [31:0] in_x_cam,
  input logic signed [31:0] in_y_cam,
  input logic signed [31:0] in_z_cam,
  input logic               out_valid,
  input logic               out_ready,
  input logic signed [25:0] out_pixel_u,
  input logic signed [25:0] out_pixel_v,
  input logic [1:0]         out_status,
  input logic               cfg_we,
  input logic [3:0]         cfg_index,
  input logic [47:0]        cfg_data
);

  // A free output stage must let the input side move.
  `PPD_ASSERT_NOW(a_ready_when_free, (!out_valid || out_ready), in_ready)
  // Status is only ever one of the three defined codes.
  `PPD_ASSERT_NOW(a_status_code, out_valid,
                  (out_status == ST_OK) || (out_status == ST_DEPTH) || (out_status == ST_SAT))
  // Bad depth results carry zero coordinates.
  `PPD_ASSERT_NOW(a_depth_zero, (out_valid && (out_status == ST_DEPTH)),
                  (out_pixel_u == 26'sd0) && (out_pixel_v == 26'sd0))
  // A stalled result word holds.
  `PPD_ASSERT_NEXT(a_out_hold, (out_valid && !out_ready),
                   out_valid && $stable(out_pixel_u) && $stable(out_pixel_v) && $stable(out_status))

endmodule

bind pinhole_projection_with_distortion_unit ppd_chk u_ppd_chk (.*);
